/* rtl/q2pr_pkg.sv */
// ----------------------------------------------------------------------------
// Quaternion to pitch and roll: shared package
// Widths, stage count, CORDIC angle table and the stage record types.
// ----------------------------------------------------------------------------
package q2pr_pkg;

  localparam int CordicStages = 16;
  localparam int MaxStages = 24;
  localparam int NStages = (CordicStages > MaxStages) ? MaxStages : CordicStages;

  // Square root: 58-bit radicand, 29-bit root.
  localparam int SqrtRootW = 29;
  localparam int SqrtBits = 29;

  // CORDIC datapath width: vector magnitude below 2^49, gain below 2.
  localparam int CordW = 52;
  localparam int AngW = 28;

  localparam logic signed [AngW-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;

  function automatic logic signed [AngW-1:0] atan_q24(input int i);
    logic signed [AngW-1:0] r;
    begin
      unique case (i)
        0: r = 28'sd13176795;
        1: r = 28'sd7778716;
        2: r = 28'sd4110060;
        3: r = 28'sd2086331;
        4: r = 28'sd1047214;
        5: r = 28'sd524117;
        6: r = 28'sd262123;
        7: r = 28'sd131069;
        default: r = (i < MaxStages) ? (AngW'(28'sd1) <<< (24 - i)) : '0;
      endcase
      return r;
    end
  endfunction

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0] z;
  } cord_t;

endpackage

/* rtl/q2pr_sqrt.sv */
// ----------------------------------------------------------------------------
// Quaternion to pitch and roll: pipelined square root
// Restoring integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module q2pr_sqrt
  import q2pr_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [57:0]          rad,
  output logic [SqrtRootW-1:0] root
);

  logic [59:0] rem [0:SqrtBits];
  logic [SqrtRootW-1:0] res [0:SqrtBits];
  logic [57:0] val [0:SqrtBits];

  assign rem[0] = '0;
  assign res[0] = '0;
  assign val[0] = rad;

  for (genvar k = 0; k < SqrtBits; k++) begin : g_bit
    logic [59:0] trial;
    logic [59:0] shifted;
    always_comb begin
      shifted = {rem[k][57:0], val[k][57:56]};
      trial = {res[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (shifted >= trial) begin
          rem[k+1] <= shifted - trial;
          res[k+1] <= {res[k][SqrtRootW-2:0], 1'b1};
        end else begin
          rem[k+1] <= shifted;
          res[k+1] <= {res[k][SqrtRootW-2:0], 1'b0};
        end
        val[k+1] <= {val[k][55:0], 2'b00};
      end
    end
  end

  assign root = res[SqrtBits];

endmodule

/* rtl/q2pr_cordic.sv */
// ----------------------------------------------------------------------------
// Quaternion to pitch and roll: pipelined vectoring CORDIC
// Quadrant fold, then one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module q2pr_cordic
  import q2pr_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [CordW-1:0] vy,
  input  logic signed [CordW-1:0] vx,
  output logic signed [AngW-1:0]  ang
);

  cord_t st [0:NStages];
  logic zero_q [0:NStages];
  cord_t fold;

  always_comb begin
    fold.x = vx;
    fold.y = vy;
    fold.z = '0;
    if (vx < 0) begin
      if (vy >= 0) begin
        fold.x = vy;
        fold.y = -vx;
        fold.z = HalfPiQ24;
      end else begin
        fold.x = -vy;
        fold.y = vx;
        fold.z = -HalfPiQ24;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= fold;
      zero_q[0] <= (vx == '0) && (vy == '0);
    end
  end

  for (genvar i = 0; i < NStages; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zero_q[i+1] <= zero_q[i];
        if (st[i].y > 0) begin
          st[i+1].x <= st[i].x + (st[i].y >>> i);
          st[i+1].y <= st[i].y - (st[i].x >>> i);
          st[i+1].z <= st[i].z + atan_q24(i);
        end else begin
          st[i+1].x <= st[i].x - (st[i].y >>> i);
          st[i+1].y <= st[i].y + (st[i].x >>> i);
          st[i+1].z <= st[i].z - atan_q24(i);
        end
      end
    end
  end

  assign ang = zero_q[NStages] ? '0 : st[NStages].z;

endmodule

/* rtl/quaternion_to_pitch_roll_unit.sv */
// ----------------------------------------------------------------------------
// Quaternion to pitch and roll: top level
// Pipeline from input transfer to output register: three arithmetic
// stages, 29 square root stages, 17 CORDIC stages and the output stage.
// Throughput: one transfer per cycle unless the output stalls; the whole pipeline advances when the
// output register is empty or being taken, so a stall loses nothing.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_pitch_roll_unit
  import q2pr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // pitch_half, roll_angle, pitch_full, pitch_clamped
);

  localparam int Lat = 3 + SqrtBits + 1 + NStages + 1;

  logic en;
  logic [Lat-1:0] vld;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_tvalid};
    end
  end

  // Stage 1: products.
  logic signed [31:0] p_wy, p_xz, p_wx, p_yz, p_xx, p_yy;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wy <= $signed(s_tdata[15:0]) * $signed(s_tdata[47:32]);
      p_xz <= $signed(s_tdata[31:16]) * $signed(s_tdata[63:48]);
      p_wx <= $signed(s_tdata[15:0]) * $signed(s_tdata[31:16]);
      p_yz <= $signed(s_tdata[47:32]) * $signed(s_tdata[63:48]);
      p_xx <= $signed(s_tdata[31:16]) * $signed(s_tdata[31:16]);
      p_yy <= $signed(s_tdata[47:32]) * $signed(s_tdata[47:32]);
    end
  end

  // Stage 2: sums.
  logic signed [33:0] s2;
  logic signed [33:0] ry2, rx2;
  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= (34'(p_wy) - 34'(p_xz)) <<< 1;
      ry2 <= (34'(p_wx) + 34'(p_yz)) <<< 1;
      rx2 <= 34'sd268435456 - ((34'(p_xx) + 34'(p_yy)) <<< 1);
    end
  end

  // Stage 3: clamp and radicands.
  logic [57:0] rad_a, rad_b;
  logic flag3;
  logic signed [33:0] ry3, rx3;
  logic signed [33:0] sc;
  always_comb begin
    sc = s2;
    if (s2 > 34'sd268435456) sc = 34'sd268435456;
    if (s2 < -34'sd268435456) sc = -34'sd268435456;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rad_a <= {30'(34'sd268435456 + sc), 28'd0};
      rad_b <= {30'(34'sd268435456 - sc), 28'd0};
      flag3 <= (s2 > 34'sd268435456) || (s2 < -34'sd268435456);
      ry3 <= ry2;
      rx3 <= rx2;
    end
  end

  logic [SqrtRootW-1:0] root_a, root_b;
  q2pr_sqrt u_sqrt_a (.clk(clk), .en(en), .rad(rad_a), .root(root_a));
  q2pr_sqrt u_sqrt_b (.clk(clk), .en(en), .rad(rad_b), .root(root_b));

  // Roll vector delayed to match the square roots; flag delayed to match the square roots and CORDIC.
  logic signed [33:0] ry_d [0:SqrtBits];
  logic signed [33:0] rx_d [0:SqrtBits];
  logic flag_d [0:SqrtBits + NStages + 1];
  assign ry_d[0] = ry3;
  assign rx_d[0] = rx3;
  assign flag_d[0] = flag3;
  for (genvar k = 0; k < SqrtBits; k++) begin : g_rdly
    always_ff @(posedge clk) begin
      if (en) begin
        ry_d[k+1] <= ry_d[k];
        rx_d[k+1] <= rx_d[k];
      end
    end
  end
  for (genvar k = 0; k < SqrtBits + NStages + 1; k++) begin : g_fdly
    always_ff @(posedge clk) begin
      if (en) flag_d[k+1] <= flag_d[k];
    end
  end

  logic signed [AngW-1:0] z_p, z_r;
  q2pr_cordic u_cord_p (
    .clk(clk), .en(en),
    .vy(CordW'({1'b0, root_a})), .vx(CordW'({1'b0, root_b})), .ang(z_p)
  );
  q2pr_cordic u_cord_r (
    .clk(clk), .en(en),
    .vy(CordW'(ry_d[SqrtBits]) <<< 16),
    .vx(CordW'(rx_d[SqrtBits]) <<< 16),
    .ang(z_r)
  );

  // Final stage: rounding, clamping and unfolding.
  logic signed [AngW:0] pa;
  logic signed [17:0] pq, rq;
  logic signed [15:0] ph, rl, pf;
  always_comb begin
    pa = ((AngW+1)'(z_p) <<< 1) - (AngW+1)'(HalfPiQ24) + 29'sd1024;
    pq = 18'(pa >>> 11);
    rq = 18'(((AngW+1)'(z_r) + 29'sd1024) >>> 11);
    ph = (pq > 18'(HalfPiQ13)) ? HalfPiQ13 :
         (pq < -18'(HalfPiQ13)) ? -HalfPiQ13 : pq[15:0];
    rl = (rq > 18'(PiQ13)) ? PiQ13 : (rq < -18'(PiQ13)) ? -PiQ13 : rq[15:0];
    if (rl > HalfPiQ13 || rl < -HalfPiQ13) begin
      pf = (ph >= 0) ? PiQ13 - ph : -PiQ13 - ph;
    end else begin
      pf = ph;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {flag_d[SqrtBits + NStages + 1], pf, rl, ph[14:0]};
    end
  end

endmodule

/* rtl/q2pr_checker.sv */
// ----------------------------------------------------------------------------
// Quaternion to pitch and roll: port checker
// Checks output holding, input readiness and the range of the roll and half pitch fields.
// ----------------------------------------------------------------------------
module q2pr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_roll: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[30:15]) <= 16'sd25736 &&
                  $signed(m_tdata[30:15]) >= -16'sd25736))
    else $error("roll out of range");

  a_pitch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[14:0]) <= 15'sd12868 &&
                  $signed(m_tdata[14:0]) >= -15'sd12868))
    else $error("pitch out of range");

endmodule

bind quaternion_to_pitch_roll_unit q2pr_checker u_q2pr_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

/* tb/tb_quaternion_to_pitch_roll_unit.sv */
// ----------------------------------------------------------------------------
// Quaternion to pitch and roll: testbench
// Sends quaternions into the unit and compares each pitch, roll, unfolded
// pitch and clamp flag against an angle predictor built from integer square
// roots and vectoring CORDIC, under several patterns of source and sink idling.
// ----------------------------------------------------------------------------
module tb_quaternion_to_pitch_roll_unit;
  import q2pr_pkg::*;

  typedef struct packed {
    logic signed [14:0] pitch_half;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_full;
    logic               pitch_clamped;
  } angles_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;

  angles_t     angle_q[$];
  int          src_idle_pct;
  int          sink_stall_pct;
  int          n_errors = 0;
  longint      cycle_cnt = 0;

  quaternion_to_pitch_roll_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint z;
    longint t;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = longint'(HalfPiQ24);
      end else begin
        x = -y; y = t; z = -longint'(HalfPiQ24);
      end
    end
    for (int i = 0; i < NStages; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_q24(i));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_q24(i));
      end
    end
    return z;
  endfunction

  function automatic longint limit(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic angles_t predict_angles(logic [63:0] q);
    longint w, x, y, z, s, a, b, ph, roll, pf;
    angles_t r;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    s = 2 * (w * y - x * z);
    r.pitch_clamped = 1'b0;
    if (s > (64'sd1 << 28)) begin
      s = 64'sd1 << 28; r.pitch_clamped = 1'b1;
    end
    if (s < -(64'sd1 << 28)) begin
      s = -(64'sd1 << 28); r.pitch_clamped = 1'b1;
    end
    a = floor_sqrt(longint'(((64'sd1 << 28) + s) << 28));
    b = floor_sqrt(longint'(((64'sd1 << 28) - s) << 28));
    ph = limit(floor_shr(2 * cordic_angle(a, b) - longint'(HalfPiQ24) + 1024, 11),
               longint'(HalfPiQ13));
    roll = limit(floor_shr(cordic_angle(2 * (w * x + y * z) * 65536,
                 ((64'sd1 << 28) - 2 * (x * x + y * y)) * 65536) + 1024, 11),
                 longint'(PiQ13));
    if (roll > longint'(HalfPiQ13) || roll < -longint'(HalfPiQ13))
      pf = (ph >= 0) ? longint'(PiQ13) - ph : -longint'(PiQ13) - ph;
    else
      pf = ph;
    r.pitch_half = ph[14:0];
    r.roll_angle = roll[15:0];
    r.pitch_full = pf[15:0];
    return r;
  endfunction

  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= {z, y, x, w};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    angle_q.push_back(predict_angles({z, y, x, w}));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (angle_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Unit quaternion from random components, scaled to Q14.
  task automatic send_unit_quat();
    real n;
    real v[4];
    for (int k = 0; k < 4; k++) v[k] = ($urandom_range(65535) - 32768.0) / 32768.0;
    n = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2] + v[3] * v[3]);
    if (n < 1.0e-3) begin
      v[0] = 1.0; n = 1.0;
    end
    send_quat(16'($rtoi(v[0] / n * 16383.0)), 16'($rtoi(v[1] / n * 16383.0)),
              16'($rtoi(v[2] / n * 16383.0)), 16'($rtoi(v[3] / n * 16383.0)));
  endtask

  task automatic test_directed();
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_quat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
    send_quat(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
    send_quat(16'sd11586, 16'sd0, 16'sd11586, 16'sd0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_quat(16'sd0, -16'sd16384, 16'sd0, 16'sd0);
    send_quat(16'sd11585, 16'sd11585, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_quat(16'sd0, 16'sd11585, 16'sd11585, 16'sd0);
    send_quat(16'sd1000, 16'sd16000, 16'sd2000, 16'sd0);
    send_quat(16'sd1000, -16'sd16000, -16'sd2000, 16'sd0);
    send_quat(16'sd16000, 16'sd0, 16'sd0, 16'sd3000);
    send_quat(16'sd0, 16'sd16384, 16'sd16384, 16'sd0);
    send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    wait_drained();
  endtask

  task automatic test_random_phase(int src_pct, int sink_pct, int n);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) != 0) send_unit_quat();
      else send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    angles_t got;
    angles_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[14:0], m_tdata[30:15], m_tdata[46:31], m_tdata[47]};
      if (angle_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("Unexpected transfer: %h", m_tdata);
      end else begin
        want = angle_q.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("Mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                     want.pitch_half, want.roll_angle, want.pitch_full,
                     want.pitch_clamped, got.pitch_half, got.roll_angle,
                     got.pitch_full, got.pitch_clamped);
        end
      end
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    src_idle_pct = 0;
    sink_stall_pct = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phase(0, 0, 450);
    test_random_phase(74, 0, 400);
    test_random_phase(0, 74, 400);
    test_random_phase(18, 18, 500);
    if (n_errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

/* quaternion_to_pitch_roll_unit.f */
rtl/q2pr_pkg.sv
rtl/q2pr_sqrt.sv
rtl/q2pr_cordic.sv
rtl/quaternion_to_pitch_roll_unit.sv
rtl/q2pr_checker.sv
tb/tb_quaternion_to_pitch_roll_unit.sv
